### design/isf_pkg.sv
// Shared types, constants and helpers of the impact and stillness fall detector.
`timescale 1ns / 1ps
`default_nettype none

package isf_pkg;

    // Accelerometer sample width and derived widths of the magnitude engine.
    localparam int SAMPLE_BITS = 16;
    localparam int AXIS_W      = SAMPLE_BITS;
    localparam int SUM_W       = 2 * SAMPLE_BITS;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int MAG_W       = 16;
    localparam int MAG_MAX     = (1 << MAG_W) - 1;
    localparam int ROOT_ITERS  = SUM_W / 2;
    localparam int ITER_W      = $clog2(ROOT_ITERS);
    localparam int NUM_AXES    = 3;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int CNT_W  = 16;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic [AXIS_W-1:0]        t_axis_abs;
    typedef logic [MAG_W-1:0]         t_mag;

    // Command codes of an input item.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_IMPACT_THR = 2'd0;
    localparam logic [IDX_W-1:0] REG_STILL_THR  = 2'd1;
    localparam logic [IDX_W-1:0] REG_STILL_TICKS = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMPACT_THR  = 16'd5120;
    localparam logic [CFG_W-1:0] RST_STILL_THR   = 16'd2458;
    localparam logic [CFG_W-1:0] RST_STILL_TICKS = 16'd150;

    // Detector phase, also the mode field of a result.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_IMPACT = 2'd1,
        PH_FALLEN = 2'd2
    } t_phase;

    // Item sequencer of the top level.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MAG,
        SEQ_UPD
    } t_seq;

    // Magnitude engine sequencer.
    typedef enum logic [1:0] {
        MAG_IDLE,
        MAG_SQ,
        MAG_ROOT,
        MAG_DONE
    } t_mag_state;

    // Status returned by the magnitude engine.
    typedef struct packed {
        logic done;
        t_mag mag;
    } t_mag_status;

    function automatic t_axis_abs abs_axis(input t_axis a);
        t_axis_abs r;
        if (a[AXIS_W-1]) begin
            r = t_axis_abs'(-a);
        end else begin
            r = t_axis_abs'(a);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/isf_mag.sv
// Magnitude engine: sum of squares on one shared multiplier, then a bit-pair square root.
`timescale 1ns / 1ps
`default_nettype none

module isf_mag (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire isf_pkg::t_axis  i_accel_x,
    input  wire isf_pkg::t_axis  i_accel_y,
    input  wire isf_pkg::t_axis  i_accel_z,
    output isf_pkg::t_mag_status o_status
);
    import isf_pkg::*;

    t_mag_state           r_state, n_state;
    logic [ITER_W-1:0]    r_cnt, n_cnt;
    t_axis_abs            r_abs [NUM_AXES];
    t_axis_abs            n_abs [NUM_AXES];
    logic [SUM_W-1:0]     r_prod, n_prod;
    logic [SUM_W-1:0]     r_acc, n_acc;
    logic [ROOT_W:0]      r_rem, n_rem;
    logic [ROOT_W-1:0]    r_root, n_root;

    t_axis_abs            sq_sel;
    logic [ROOT_W+2:0]    cand;
    logic [ROOT_W+2:0]    trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MAG_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_abs  <= n_abs;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    // Axis fed to the multiplier in the current squaring step.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_sel = r_abs[0];
            2'd1:    sq_sel = r_abs[1];
            2'd2:    sq_sel = r_abs[2];
            default: sq_sel = '0;
        endcase
    end

    // One root digit per step: bring down the next two radicand bits.
    assign cand  = {r_rem, r_acc[SUM_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_abs   = r_abs;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_root  = r_root;

        unique case (r_state)
            MAG_IDLE: begin
                if (i_start) begin
                    n_abs[0] = abs_axis(i_accel_x);
                    n_abs[1] = abs_axis(i_accel_y);
                    n_abs[2] = abs_axis(i_accel_z);
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_state  = MAG_SQ;
                end
            end
            MAG_SQ: begin
                // Product of step k is added in step k + 1.
                n_prod = SUM_W'(sq_sel) * SUM_W'(sq_sel);
                if (r_cnt != '0) begin
                    n_acc = r_acc + r_prod;
                end
                if (r_cnt == ITER_W'(NUM_AXES)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_root  = '0;
                    n_state = MAG_ROOT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            MAG_ROOT: begin
                n_acc = r_acc << 2;
                if (cand >= trial) begin
                    n_rem  = (ROOT_W + 1)'(cand - trial);
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = cand[ROOT_W:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                if (r_cnt == ITER_W'(ROOT_ITERS - 1)) begin
                    n_state = MAG_DONE;
                end
                n_cnt = r_cnt + 1'b1;
            end
            MAG_DONE: begin
                n_state = MAG_IDLE;
            end
            default: begin
                n_state = MAG_IDLE;
            end
        endcase
    end

    // A root beyond the magnitude field saturates to its full scale.
    assign o_status.done = (r_state == MAG_DONE);
    assign o_status.mag  = (r_root > ROOT_W'(MAG_MAX)) ? '1 : MAG_W'(r_root);

endmodule

`default_nettype wire

### design/impact_stillness_fall_detector.sv
// Top level of the impact and stillness fall detector.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_cmd, i_accel_x/y/z, i_time_ms
// result    out        o_out_valid / i_out_ready    o_mode, o_fall_flag, o_magnitude,
//                                                   o_event_time, o_event_peak
// config    in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// A sample goes from its transfer to a valid result through squaring and summing on the single
// multiplier, sixteen iterations of the bit-pair square root, the engine's done state and the
// update state. A clear item skips the engine and goes straight to the update. The input is ready
// again in the cycle after the result is loaded, so an unread result only stalls the next one.
// Reset is synchronous and active low; it restores the configuration defaults and clears the
// detector state and the saved event.

module impact_stillness_fall_detector (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Input items
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire                            i_cmd,
    input  wire isf_pkg::t_axis            i_accel_x,
    input  wire isf_pkg::t_axis            i_accel_y,
    input  wire isf_pkg::t_axis            i_accel_z,
    input  wire  [isf_pkg::TIME_W-1:0]     i_time_ms,
    // Result items
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [1:0]                     o_mode,
    output logic                           o_fall_flag,
    output isf_pkg::t_mag                  o_magnitude,
    output logic [isf_pkg::TIME_W-1:0]     o_event_time,
    output isf_pkg::t_mag                  o_event_peak,
    // Configuration writes
    input  wire                            i_cfg_we,
    input  wire  [isf_pkg::IDX_W-1:0]      i_cfg_idx,
    input  wire  [isf_pkg::CFG_W-1:0]      i_cfg_data
);
    import isf_pkg::*;

    // Item sequencer and the captured item.
    t_seq               r_seq, n_seq;
    logic               r_cmd, n_cmd;
    logic [TIME_W-1:0]  r_time, n_time;
    t_mag               r_mag, n_mag;

    // Configuration registers.
    logic [CFG_W-1:0]   r_cfg_impact;
    logic [CFG_W-1:0]   r_cfg_still;
    logic [CFG_W-1:0]   r_cfg_ticks;

    // Detector state.
    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_still_cnt, n_still_cnt;
    t_mag               r_peak, n_peak;
    logic [TIME_W-1:0]  r_imp_time, n_imp_time;
    logic               r_flag, n_flag;
    logic [TIME_W-1:0]  r_saved_time, n_saved_time;
    t_mag               r_saved_peak, n_saved_peak;

    // Output register.
    logic               r_out_valid, n_out_valid;
    t_phase             r_out_mode;
    logic               r_out_flag;
    t_mag               r_out_mag;
    logic [TIME_W-1:0]  r_out_time;
    t_mag               r_out_peak;

    logic               in_xfer;
    logic               mag_start;
    logic               ld;
    logic [CNT_W-1:0]   cnt_inc;
    t_mag               peak_upd;
    t_mag_status        mag_st;

    assign o_in_ready = (r_seq == SEQ_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign mag_start  = in_xfer && (i_cmd == CMD_SAMPLE);

    // The output register can take a new result when empty or being emptied.
    assign ld = (r_seq == SEQ_UPD) && (!r_out_valid || i_out_ready);

    isf_mag u_mag (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mag_start),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .o_status  (mag_st)
    );

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_impact <= RST_IMPACT_THR;
            r_cfg_still  <= RST_STILL_THR;
            r_cfg_ticks  <= RST_STILL_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMPACT_THR:  r_cfg_impact <= i_cfg_data;
                REG_STILL_THR:   r_cfg_still  <= i_cfg_data;
                REG_STILL_TICKS: r_cfg_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SEQ_IDLE;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_IDLE;
            r_still_cnt  <= '0;
            r_peak       <= '0;
            r_imp_time   <= '0;
            r_flag       <= 1'b0;
            r_saved_time <= '0;
            r_saved_peak <= '0;
        end else begin
            r_seq        <= n_seq;
            r_out_valid  <= n_out_valid;
            r_phase      <= n_phase;
            r_still_cnt  <= n_still_cnt;
            r_peak       <= n_peak;
            r_imp_time   <= n_imp_time;
            r_flag       <= n_flag;
            r_saved_time <= n_saved_time;
            r_saved_peak <= n_saved_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_time <= n_time;
        r_mag  <= n_mag;
        if (ld) begin
            r_out_mode <= n_phase;
            r_out_flag <= n_flag;
            r_out_mag  <= r_mag;
            r_out_time <= n_saved_time;
            r_out_peak <= n_saved_peak;
        end
    end

    // The still counter saturates at its full scale.
    assign cnt_inc  = (r_still_cnt == '1) ? r_still_cnt : r_still_cnt + 1'b1;
    assign peak_upd = (r_mag > r_peak) ? r_mag : r_peak;

    // Sequencer and the detector update, committed when the result is loaded.
    always_comb begin
        n_seq        = r_seq;
        n_cmd        = r_cmd;
        n_time       = r_time;
        n_mag        = r_mag;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_phase      = r_phase;
        n_still_cnt  = r_still_cnt;
        n_peak       = r_peak;
        n_imp_time   = r_imp_time;
        n_flag       = r_flag;
        n_saved_time = r_saved_time;
        n_saved_peak = r_saved_peak;

        unique case (r_seq)
            SEQ_IDLE: begin
                if (in_xfer) begin
                    n_cmd  = i_cmd;
                    n_time = i_time_ms;
                    if (i_cmd == CMD_CLEAR) begin
                        // A clear reports a zero magnitude and skips the engine.
                        n_mag = '0;
                        n_seq = SEQ_UPD;
                    end else begin
                        n_seq = SEQ_MAG;
                    end
                end
            end
            SEQ_MAG: begin
                if (mag_st.done) begin
                    n_mag = mag_st.mag;
                    n_seq = SEQ_UPD;
                end
            end
            SEQ_UPD: begin
                if (ld) begin
                    n_out_valid = 1'b1;
                    n_seq       = SEQ_IDLE;
                    if (r_cmd == CMD_CLEAR) begin
                        n_phase     = PH_IDLE;
                        n_flag      = 1'b0;
                        n_still_cnt = '0;
                        n_peak      = '0;
                    end else begin
                        unique case (r_phase)
                            PH_IDLE: begin
                                if (r_mag > r_cfg_impact) begin
                                    n_phase     = PH_IMPACT;
                                    n_still_cnt = '0;
                                    n_peak      = r_mag;
                                    n_imp_time  = r_time;
                                end
                            end
                            PH_IMPACT: begin
                                n_peak = peak_upd;
                                if (r_mag > r_cfg_still) begin
                                    // Renewed motion cancels the detection.
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_still_cnt = cnt_inc;
                                    if (cnt_inc >= r_cfg_ticks) begin
                                        n_phase      = PH_FALLEN;
                                        n_flag       = 1'b1;
                                        n_saved_time = r_imp_time;
                                        n_saved_peak = peak_upd;
                                    end
                                end
                            end
                            // While fallen, samples change nothing until a clear.
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode       = r_out_mode;
    assign o_fall_flag  = r_out_flag;
    assign o_magnitude  = r_out_mag;
    assign o_event_time = r_out_time;
    assign o_event_peak = r_out_peak;

    // The flag is set exactly while a confirmed fall is held.
    a_flag_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag == (r_phase == PH_FALLEN))
        else $error("fall flag and phase disagree");

    // The magnitude engine only finishes while the sequencer waits for it.
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mag_st.done |-> r_seq == SEQ_MAG)
        else $error("magnitude finished outside of its wait state");

    // A clear result reports idle, no flag and a zero magnitude.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && r_cmd == CMD_CLEAR) |=>
            (o_out_valid && o_mode == PH_IDLE && !o_fall_flag && o_magnitude == '0))
        else $error("clear item produced a wrong result");

    // No new item enters while a result is still being formed.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SEQ_MAG || r_seq == SEQ_UPD) |-> !o_in_ready)
        else $error("input ready while an item is in work");

endmodule

`default_nettype wire
